@@ sv/ppg_pkg.sv @@
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared types, codes and helper functions of the predator/prey grid update.
// ----------------------------------------------------------------------------
package ppg_pkg;

   localparam logic [1:0] KIND_EMPTY  = 2'd0;
   localparam logic [1:0] KIND_SHARK  = 2'd1;
   localparam logic [1:0] KIND_FISH   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] CSR_FISH_REP     = 2'd0;
   localparam logic [1:0] CSR_SHARK_REP    = 2'd1;
   localparam logic [1:0] CSR_SHARK_STARVE = 2'd2;

   localparam logic [7:0] FISH_REP_RESET     = 8'd15;
   localparam logic [7:0] SHARK_REP_RESET    = 8'd8;
   localparam logic [7:0] SHARK_STARVE_RESET = 8'd10;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_UPDATE,
      CMD_READ,
      CMD_ADVANCE
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_SKIP,
      ACT_STAY,
      ACT_MOVE,
      ACT_EAT,
      ACT_STARVE,
      ACT_ACCESS
   } act_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_EVAL,
      ST_WR_O,
      ST_WR_D,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] age;
      logic [7:0]  breed;
      logic [7:0]  hunger;
   } cell_type;

   typedef struct packed {
      logic [7:0] fish_rep;
      logic [7:0] shark_rep;
      logic [7:0] shark_starve;
   } csr_type;

   typedef struct packed {
      act_type    act;
      logic [1:0] dir;
      logic [7:0] nb;
      logic [7:0] hg;
      logic       off;
      cell_type   o_cell;
      cell_type   d_cell;
   } eval_type;

   function automatic logic [7:0] sat_inc_f(input logic [7:0] v);
      sat_inc_f = (v == 8'hFF) ? 8'hFF : v + 8'd1;
   endfunction

   // residue mod 3 by summing base-4 digits, then a few compare and subtract steps
   function automatic logic [1:0] mod3_f(input logic [14:0] v);
      logic [4:0] s;
      int i;
      s = 5'd0;
      for (i = 0; i < 7; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      s = s + 5'(v[14]);
      if (s >= 5'd12) s = s - 5'd12;
      if (s >= 5'd12) s = s - 5'd12;
      if (s >= 5'd6)  s = s - 5'd6;
      if (s >= 5'd3)  s = s - 5'd3;
      mod3_f = s[1:0];
   endfunction

endpackage

@@ sv/ppg_ram.sv @@
// ----------------------------------------------------------------------------
// ppg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppg_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/ppg_eval.sv @@
// ----------------------------------------------------------------------------
// ppg_eval
// Decides the move of one creature from its cell and its four neighbours.
// ----------------------------------------------------------------------------
module ppg_eval (
   input  ppg_pkg::cell_type        own,
   input  logic [3:0][1:0]          nk,
   input  logic [1:0]               rnd_lo,
   input  logic [1:0]               rnd_m3,
   input  ppg_pkg::csr_type         csr,
   input  logic [15:0]              chron,
   output ppg_pkg::eval_type        res
);
   import ppg_pkg::*;

   logic [3:0]  free_m;
   logic [3:0]  fish_m;
   logic [3:0]  mask;
   logic [2:0]  cnt;
   logic [1:0]  pick;
   logic [2:0]  rank;
   logic        found;
   logic        shark;
   logic [15:0] done;
   logic [7:0]  nb;
   logic [7:0]  hg;
   logic [7:0]  lim;
   int          d;

   always_comb begin
      for (d = 0; d < 4; d++) begin
         free_m[d] = (nk[d] == KIND_EMPTY);
         fish_m[d] = (nk[d] == KIND_FISH);
      end
      shark = (own.kind == KIND_SHARK);
      done  = chron + 16'd1;
      nb    = sat_inc_f(own.breed);
      hg    = shark ? sat_inc_f(own.hunger) : 8'd0;
      lim   = shark ? csr.shark_rep : csr.fish_rep;
      mask  = 4'd0;
      res   = '0;

      priority if (own.kind == KIND_EMPTY || own.age == done) begin
         res.act = ACT_SKIP;
      end else if (shark && (|fish_m)) begin
         res.act = ACT_EAT;
         mask    = fish_m;
         hg      = 8'd0;
      end else if (shark && hg == csr.shark_starve) begin
         res.act = ACT_STARVE;
      end else if (|free_m) begin
         res.act = ACT_MOVE;
         mask    = free_m;
      end else begin
         res.act = ACT_STAY;
      end

      cnt = 3'($countones(mask));
      unique case (cnt)
         3'd2:    pick = {1'b0, rnd_lo[0]};
         3'd3:    pick = rnd_m3;
         3'd4:    pick = rnd_lo;
         default: pick = 2'd0;
      endcase

      // the pick-th candidate in scan order
      rank  = 3'd0;
      found = 1'b0;
      for (d = 0; d < 4; d++) begin
         if (mask[d]) begin
            if (!found && rank == {1'b0, pick}) begin
               res.dir = 2'(d);
               found   = 1'b1;
            end
            rank = rank + 3'd1;
         end
      end

      res.off = (res.act != ACT_STAY) && (res.act != ACT_SKIP) && (nb > lim);
      res.nb  = res.off ? 8'd0 : nb;
      res.hg  = hg;

      if (res.act == ACT_STAY) begin
         res.o_cell = '{kind: own.kind, age: done, breed: nb, hunger: hg};
      end else if (res.off) begin
         res.o_cell = '{kind: own.kind, age: chron, breed: 8'd0, hunger: 8'd0};
      end else begin
         res.o_cell = '0;
      end
      res.d_cell = '{kind: own.kind, age: done, breed: res.nb, hunger: hg};
   end

endmodule

@@ sv/predator_prey_grid_update.sv @@
// Flow: a request passes through position wrap, memory reads of the own cell and
// its four neighbours, one decision, up to two writes and the response load.
// Positions at or beyond the grid size are wrapped by repeated subtraction.
// A new request is accepted only after the previous one has loaded its response.
// Reset: after reset a clearing pass writes all GRID_WIDTH*GRID_HEIGHT cells,
// one a cycle, with req_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// predator_prey_grid_update
// Toroidal fish-and-shark grid held in one cell memory, updated per command.
// ----------------------------------------------------------------------------
module predator_prey_grid_update #(
   parameter int GRID_WIDTH  = 128,
   parameter int GRID_HEIGHT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x[6:0], pos_y[13:7], rand_value[28:14], write_kind[30:29]
   input  logic [31:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_kind[1:0], breed_count[9:2], hunger_count[17:10], action[20:18],
   // dest_x[27:21], dest_y[34:28], offspring[35], chronon_now[51:36]
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import ppg_pkg::*;

   localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW     = $clog2(NCELLS);
   localparam int XW     = $clog2(GRID_WIDTH);
   localparam int YW     = $clog2(GRID_HEIGHT);
   localparam int CW     = $bits(cell_type);

   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   cmd_type         cmd_ff, cmd_in;
   logic [6:0]      rx_ff, rx_in;
   logic [6:0]      ry_ff, ry_in;
   logic [1:0]      rlo_ff, rlo_in;
   logic [1:0]      r3_ff, r3_in;
   logic [1:0]      wk_ff, wk_in;
   logic [2:0]      idx_ff, idx_in;
   cell_type        own_ff, own_in;
   logic [3:0][1:0] nk_ff, nk_in;
   eval_type        res_ff, res_in;
   logic [15:0]     chron_ff, chron_in;
   csr_type         csr_ff, csr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [55:0]     rsp_data_ff, rsp_data_in;

   logic [XW-1:0]   xs;
   logic [YW-1:0]   ys;
   logic [XW-1:0]   nxa [4];
   logic [YW-1:0]   nya [4];
   logic [AW-1:0]   naddr [4];
   logic [AW-1:0]   oaddr;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [AW-1:0]   ram_raddr;
   cell_type        ram_wdata;
   cell_type        ram_rdata;
   logic [CW-1:0]   ram_rbits;
   eval_type        eval_res;
   logic [1:0]      rd_dir;
   logic            upd_live;
   logic            moved;
   act_type         act_o;
   logic [7:0]      breed_o;
   logic [7:0]      hunger_o;
   logic [6:0]      dx_o;
   logic [6:0]      dy_o;
   logic [15:0]     chron_o;
   logic [1:0]      wkind;

   function automatic logic [AW-1:0] addr_f(input logic [XW-1:0] x, input logic [YW-1:0] y);
      addr_f = AW'(x) * AW'(GRID_HEIGHT) + AW'(y);
   endfunction

   assign xs = XW'(rx_ff);
   assign ys = YW'(ry_ff);

   // neighbours: down, right, up, left
   always_comb begin
      nxa[0] = xs;
      nya[0] = (ys == YW'(GRID_HEIGHT - 1)) ? '0 : ys + YW'(1);
      nxa[1] = (xs == XW'(GRID_WIDTH - 1)) ? '0 : xs + XW'(1);
      nya[1] = ys;
      nxa[2] = xs;
      nya[2] = (ys == '0) ? YW'(GRID_HEIGHT - 1) : ys - YW'(1);
      nxa[3] = (xs == '0) ? XW'(GRID_WIDTH - 1) : xs - XW'(1);
      nya[3] = ys;
      for (int i = 0; i < 4; i++) begin
         naddr[i] = addr_f(nxa[i], nya[i]);
      end
   end

   assign oaddr = addr_f(xs, ys);

   ppg_ram #(
      .WIDTH (CW),
      .DEPTH (NCELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );

   assign ram_rdata = cell_type'(ram_rbits);

   ppg_eval u_eval (
      .own    (own_ff),
      .nk     (nk_ff),
      .rnd_lo (rlo_ff),
      .rnd_m3 (r3_ff),
      .csr    (csr_ff),
      .chron  (chron_ff),
      .res    (eval_res)
   );

   assign rd_dir    = 2'(idx_ff - 3'd1);
   assign ram_raddr = (idx_ff == 3'd0) ? oaddr : naddr[rd_dir];
   assign upd_live  = (cmd_ff == CMD_UPDATE) && (res_ff.act != ACT_SKIP);
   assign moved     = upd_live && (res_ff.act == ACT_MOVE || res_ff.act == ACT_EAT);
   assign wkind     = (wk_ff == KIND_UNUSED) ? KIND_EMPTY : wk_ff;

   always_comb begin
      act_o    = (cmd_ff == CMD_UPDATE) ? res_ff.act : ACT_ACCESS;
      breed_o  = upd_live ? res_ff.nb : ((cmd_ff == CMD_WRITE) ? 8'd0 : own_ff.breed);
      hunger_o = upd_live ? res_ff.hg : ((cmd_ff == CMD_WRITE) ? 8'd0 : own_ff.hunger);
      dx_o     = moved ? 7'(nxa[res_ff.dir]) : 7'(xs);
      dy_o     = moved ? 7'(nya[res_ff.dir]) : 7'(ys);
      chron_o  = (cmd_ff == CMD_ADVANCE) ? chron_ff + 16'd1 : chron_ff;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rlo_in       = rlo_ff;
      r3_in        = r3_ff;
      wk_in        = wk_ff;
      idx_in       = idx_ff;
      own_in       = own_ff;
      nk_in        = nk_ff;
      res_in       = res_ff;
      chron_in     = chron_ff;
      csr_in       = csr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = oaddr;
      ram_wdata    = res_ff.o_cell;

      if (csr_valid) begin
         case (csr_index)
            CSR_FISH_REP:     csr_in.fish_rep     = csr_data;
            CSR_SHARK_REP:    csr_in.shark_rep    = csr_data;
            CSR_SHARK_STARVE: csr_in.shark_starve = csr_data;
            default:          ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NCELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               rx_in    = req_tdata[6:0];
               ry_in    = req_tdata[13:7];
               rlo_in   = req_tdata[15:14];
               r3_in    = mod3_f(req_tdata[28:14]);
               wk_in    = req_tdata[30:29];
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // wrap positions into the grid, one subtraction per cycle
            if ({4'd0, rx_ff} >= 11'(GRID_WIDTH)) begin
               rx_in = rx_ff - 7'(GRID_WIDTH);
            end
            if ({4'd0, ry_ff} >= 11'(GRID_HEIGHT)) begin
               ry_in = ry_ff - 7'(GRID_HEIGHT);
            end
            if ({4'd0, rx_ff} < 11'(GRID_WIDTH) && {4'd0, ry_ff} < 11'(GRID_HEIGHT)) begin
               idx_in   = 3'd0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // own cell read first, the registered read data arrives in the cycle after its address
            if (idx_ff == 3'd1) begin
               own_in = ram_rdata;
            end else if (idx_ff != 3'd0) begin
               nk_in[2'(idx_ff - 3'd2)] = ram_rdata.kind;
            end
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd5) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            res_in = eval_res;
            if (cmd_ff == CMD_WRITE ||
                (cmd_ff == CMD_UPDATE && eval_res.act != ACT_SKIP)) begin
               state_in = ST_WR_O;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WR_O: begin
            ram_we = 1'b1;
            if (cmd_ff == CMD_WRITE) begin
               ram_wdata = '{kind: wkind, age: chron_ff, breed: 8'd0, hunger: 8'd0};
            end
            state_in = moved ? ST_WR_D : ST_DONE;
         end
         ST_WR_D: begin
            ram_we    = 1'b1;
            ram_waddr = naddr[res_ff.dir];
            ram_wdata = res_ff.d_cell;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, chron_o, upd_live & res_ff.off, dy_o, dx_o,
                               act_o, hunger_o, breed_o, own_ff.kind};
               chron_in     = chron_o;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chron_ff     <= 16'd0;
         csr_ff       <= '{fish_rep: FISH_REP_RESET, shark_rep: SHARK_REP_RESET,
                           shark_starve: SHARK_STARVE_RESET};
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chron_ff     <= chron_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      rlo_ff      <= rlo_in;
      r3_ff       <= r3_in;
      wk_ff       <= wk_in;
      own_ff      <= own_in;
      nk_ff       <= nk_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/ppg_chk.sv @@
// ----------------------------------------------------------------------------
// ppg_chk
// Port-level checks of the predator/prey grid update, bound to the top level.
// ----------------------------------------------------------------------------
module ppg_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   import ppg_pkg::*;

   logic [2:0] act;
   assign act = rsp_tdata[20:18];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_act_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> act == ACT_SKIP || act == ACT_STAY || act == ACT_MOVE ||
                     act == ACT_EAT || act == ACT_STARVE || act == ACT_ACCESS)
      else $error("response carries an undefined action");

   a_offspring: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> act == ACT_MOVE || act == ACT_EAT ||
                                      act == ACT_STARVE)
      else $error("offspring without the creature leaving its cell");

   a_eat_fed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && act == ACT_EAT |-> rsp_tdata[17:10] == 8'd0 &&
                                       rsp_tdata[1:0] == KIND_SHARK)
      else $error("eating shark not fed");

endmodule

bind predator_prey_grid_update ppg_chk u_ppg_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
